>>> hdl/dmf_pkg.sv
// ----------------------------------------------------------------------------
// dmf_pkg
// Shared constants, types and register codes of the 3x3 depth median filter.
// ----------------------------------------------------------------------------
package dmf_pkg;

	localparam int MAX_WIDTH  = 512;
	localparam int MAX_HEIGHT = 1024;
	localparam int DEPTH_BITS = 16;
	localparam int MIN_DIM    = 3;

	// raster counters: the row counter also covers the two tail rows
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT + 2);

	// register and field widths
	localparam int FW_W       = 10;
	localparam int FH_W       = 11;
	localparam int OROW_W     = 10;
	localparam int OCOL_W     = 9;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;

	localparam logic [FW_W-1:0] FW_RESET = FW_W'(512);
	localparam logic [FH_W-1:0] FH_RESET = FH_W'(424);

	// line ram word: upper row in the high half, middle row in the low half
	localparam int LINE_W = 2 * DEPTH_BITS;

	localparam int WIN_N   = 9;
	localparam int WIN_MID = 4;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// output tdata layout
	localparam int OUT_DEPTH_LSB = 0;
	localparam int OUT_ROW_LSB   = OUT_DEPTH_LSB + DEPTH_BITS;
	localparam int OUT_COL_LSB   = OUT_ROW_LSB + OROW_W;
	localparam int OUT_USED_W    = OUT_COL_LSB + OCOL_W;
	localparam int OUT_TDATA_W   = ((OUT_USED_W + 7) / 8) * 8;
	localparam int IN_TDATA_W    = ((DEPTH_BITS + 7) / 8) * 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef logic [DEPTH_BITS-1:0] pix_t;
	typedef pix_t [WIN_N-1:0] win_t;

	// one classified pixel waiting for the median unit
	typedef struct packed {
		win_t              win;
		logic              border;
		logic [OROW_W-1:0] row;
		logic [OCOL_W-1:0] col;
		logic              last;
	} job_t;

	typedef struct packed {
		logic push;
		job_t job;
	} push_t;

	typedef struct packed {
		logic avail;
		job_t job;
	} head_t;

endpackage

>>> hdl/dmf_ram.sv
// ----------------------------------------------------------------------------
// dmf_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dmf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> hdl/dmf_front.sv
// ----------------------------------------------------------------------------
// dmf_front
// Raster tracking, line ram, 3x3 window and classification of each pixel.
// ----------------------------------------------------------------------------
module dmf_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  dmf_pkg::pix_t             pixel_depth,
	input  logic                      flush,
	input  logic [dmf_pkg::FW_W-1:0]  frame_w,
	input  logic [dmf_pkg::FH_W-1:0]  frame_h,
	input  logic                      q_full,
	output dmf_pkg::push_t            push
);
	import dmf_pkg::*;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             accept;
	logic             fire_s1;

	// classification of the incoming position
	pix_t             d0;
	logic             col_nz;
	logic             emit0;
	logic [ROW_W-1:0] orow0;
	logic [COL_W-1:0] ocol0;
	logic             last0;
	logic             border0;
	logic [COL_W:0]   col_inc;
	logic [FH_W:0]    h_plus1;

	// stage 1: line ram data is out
	logic              valid_s1;
	logic [COL_W-1:0]  c_s1;
	pix_t              d_s1;
	logic              emit_s1;
	logic              border_s1;
	logic [OROW_W-1:0] orow_s1;
	logic [OCOL_W-1:0] ocol_s1;
	logic              last_s1;
	logic              byp_s1;
	logic [LINE_W-1:0] byp_data_s1;

	logic [LINE_W-1:0] ram_rd;
	logic [LINE_W-1:0] line;
	logic [LINE_W-1:0] wr_word;
	pix_t              up;
	pix_t              mid;
	win_t              win_q;
	win_t              win_next;

	assign accept   = s_tvalid && s_tready;
	assign fire_s1  = valid_s1 && (!emit_s1 || !q_full);
	assign s_tready = !valid_s1 || fire_s1;

	always_comb begin
		d0      = flush ? '0 : pixel_depth;
		col_nz  = (col_q != '0);
		emit0   = (row_q >= ROW_W'(2)) || ((row_q == ROW_W'(1)) && col_nz);
		orow0   = col_nz ? (row_q - ROW_W'(1)) : (row_q - ROW_W'(2));
		ocol0   = col_nz ? (col_q - COL_W'(1)) : COL_W'(frame_w - FW_W'(1));
		h_plus1 = {1'b0, frame_h} + (FH_W+1)'(1);
		last0   = ((FH_W+1)'(row_q) >= h_plus1);
		border0 = (orow0 == '0) || (orow0 == ROW_W'(frame_h - FH_W'(1)))
			|| (ocol0 == '0) || (FW_W'(ocol0) == (frame_w - FW_W'(1)));
		col_inc = {1'b0, col_q} + (COL_W+1)'(1);
	end

	// raster position of the next item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last0) begin
				col_q <= '0;
				row_q <= '0;
			end else if (FW_W'(col_inc) >= frame_w) begin
				col_q <= '0;
				row_q <= row_q + ROW_W'(1);
			end else begin
				col_q <= COL_W'(col_inc);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			c_s1        <= col_q;
			d_s1        <= d0;
			emit_s1     <= emit0;
			border_s1   <= border0;
			orow_s1     <= OROW_W'(orow0);
			ocol_s1     <= OCOL_W'(ocol0);
			last_s1     <= last0;
			// a write to the same column in this cycle wins over the ram read
			byp_s1      <= fire_s1 && (c_s1 == col_q);
			byp_data_s1 <= wr_word;
		end
	end

	dmf_ram #(
		.WIDTH (LINE_W),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk     (clk),
		.wr_en   (fire_s1),
		.wr_addr (c_s1),
		.wr_data (wr_word),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (ram_rd)
	);

	always_comb begin
		line    = byp_s1 ? byp_data_s1 : ram_rd;
		up      = line[LINE_W-1:DEPTH_BITS];
		mid     = line[DEPTH_BITS-1:0];
		wr_word = {mid, d_s1};
		for (int k = 0; k < 3; k++) begin
			win_next[k*3+0] = win_q[k*3+1];
			win_next[k*3+1] = win_q[k*3+2];
		end
		win_next[2] = up;
		win_next[5] = mid;
		win_next[8] = d_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (fire_s1) begin
			win_q <= win_next;
		end
	end

	assign push.push       = fire_s1 && emit_s1;
	assign push.job.win    = win_next;
	assign push.job.border = border_s1;
	assign push.job.row    = orow_s1;
	assign push.job.col    = ocol_s1;
	assign push.job.last   = last_s1;

endmodule

>>> hdl/dmf_queue.sv
// ----------------------------------------------------------------------------
// dmf_queue
// Short job queue between the classifying front and the median back end.
// ----------------------------------------------------------------------------
module dmf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  dmf_pkg::push_t push,
	output logic           full,
	input  logic           pop,
	output dmf_pkg::head_t head
);
	import dmf_pkg::*;

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_pop;

	assign full       = (count_q == (QPTR_W+1)'(QDEPTH));
	assign head.avail = (count_q != '0);
	assign head.job   = mem_q[rd_ptr_q];
	assign do_pop     = pop && head.avail;

	always_ff @(posedge clk) begin
		if (push.push) begin
			mem_q[wr_ptr_q] <= push.job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push.push && !do_pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (!push.push && do_pop) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

>>> hdl/dmf_back.sv
// ----------------------------------------------------------------------------
// dmf_back
// Pipelined nine-input median network with border bypass and output register.
// ----------------------------------------------------------------------------
module dmf_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dmf_pkg::head_t               head,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output dmf_pkg::pix_t                out_depth,
	output logic [dmf_pkg::OROW_W-1:0]   out_row,
	output logic [dmf_pkg::OCOL_W-1:0]   out_col,
	output logic                         out_last
);
	import dmf_pkg::*;

	typedef logic [$clog2(WIN_N)-1:0] widx_t;

	typedef struct packed {
		logic              border;
		pix_t              center;
		logic [OROW_W-1:0] row;
		logic [OCOL_W-1:0] col;
		logic              last;
	} meta_t;

	// compare-exchange: smaller value to index a
	function automatic win_t cas(input win_t w, input widx_t a, input widx_t b);
		win_t r;
		r = w;
		if (w[a] > w[b]) begin
			r[a] = w[b];
			r[b] = w[a];
		end
		return r;
	endfunction

	logic  vld_s1, vld_s2, vld_s3;
	logic  rdy1, rdy2, rdy3, rdy4;
	win_t  win_s1, win_s2, win_s3;
	meta_t meta_s1, meta_s2, meta_s3;
	meta_t meta_in;
	win_t  net1, net2, net3, net4;

	assign rdy4 = !out_valid || out_ready;
	assign rdy3 = !vld_s3 || rdy4;
	assign rdy2 = !vld_s2 || rdy3;
	assign rdy1 = !vld_s1 || rdy2;
	assign pop  = head.avail && rdy1;

	always_comb begin
		meta_in.border = head.job.border;
		meta_in.center = head.job.win[WIN_MID];
		meta_in.row    = head.job.row;
		meta_in.col    = head.job.col;
		meta_in.last   = head.job.last;

		net1 = head.job.win;
		net1 = cas(net1, 4'd1, 4'd2);
		net1 = cas(net1, 4'd4, 4'd5);
		net1 = cas(net1, 4'd7, 4'd8);
		net1 = cas(net1, 4'd0, 4'd1);
		net1 = cas(net1, 4'd3, 4'd4);
		net1 = cas(net1, 4'd6, 4'd7);

		net2 = win_s1;
		net2 = cas(net2, 4'd1, 4'd2);
		net2 = cas(net2, 4'd4, 4'd5);
		net2 = cas(net2, 4'd7, 4'd8);
		net2 = cas(net2, 4'd0, 4'd3);
		net2 = cas(net2, 4'd5, 4'd8);
		net2 = cas(net2, 4'd4, 4'd7);

		net3 = win_s2;
		net3 = cas(net3, 4'd3, 4'd6);
		net3 = cas(net3, 4'd1, 4'd4);
		net3 = cas(net3, 4'd2, 4'd5);
		net3 = cas(net3, 4'd4, 4'd7);

		net4 = win_s3;
		net4 = cas(net4, 4'd4, 4'd2);
		net4 = cas(net4, 4'd6, 4'd4);
		net4 = cas(net4, 4'd4, 4'd2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= pop;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) out_valid <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			win_s1  <= net1;
			meta_s1 <= meta_in;
		end
		if (rdy2) begin
			win_s2  <= net2;
			meta_s2 <= meta_s1;
		end
		if (rdy3) begin
			win_s3  <= net3;
			meta_s3 <= meta_s2;
		end
		if (rdy4) begin
			out_depth <= meta_s3.border ? meta_s3.center : net4[WIN_MID];
			out_row   <= meta_s3.row;
			out_col   <= meta_s3.col;
			out_last  <= meta_s3.last;
		end
	end

endmodule

>>> hdl/depth_median_filter_3x3_core.sv
// ----------------------------------------------------------------------------
// depth_median_filter_3x3_core
// 3x3 median filter over a raster stream of depth pixels.
// ----------------------------------------------------------------------------
// usage
//   s_* channel: one depth pixel per transaction in raster order, tuser = flush
//   (padding, depth taken as zero). after the last pixel of a frame send
//   frame_width + 1 flush items to drain the tail.
//   m_* channel: one filtered pixel per transaction with its row and column;
//   tlast marks the last pixel of the frame. border pixels pass unchanged.
//   cfg_* channel: register writes, index 0 = frame_width, 1 = frame_height,
//   always ready; write only while the stream is idle.
// throughput: one pixel per clock sustained while m_tready is high; the line
//   ram does one read and one write per cycle, which sets that figure.
// path: after the transaction completing its neighborhood (one row plus one
//   pixel behind the input) a result crosses front, queue, median, output.
// reset: raster position to zero, window cleared, registers to 512 x 424,
//   no clearing pass over the line ram.
// stall: when m_tready is low the output holds, the median pipeline and the
//   4-entry job queue fill, then s_tready drops.
// ----------------------------------------------------------------------------
module depth_median_filter_3x3_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [dmf_pkg::IN_TDATA_W-1:0]      s_tdata,   // pixel_depth
	input  logic                                s_tuser,   // flush
	// output stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [dmf_pkg::OUT_TDATA_W-1:0]     m_tdata,   // filtered_depth, out_row, out_col, zero fill
	output logic                                m_tlast,   // end_of_frame
	// configuration writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dmf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dmf_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import dmf_pkg::*;

	logic [FW_W-1:0]   frame_width_q;
	logic [FH_W-1:0]   frame_height_q;
	logic [FW_W-1:0]   frame_w;
	logic [FH_W-1:0]   frame_h;

	push_t             push;
	head_t             head;
	logic              q_full;
	logic              pop;

	pix_t              out_depth;
	logic [OROW_W-1:0] out_row;
	logic [OCOL_W-1:0] out_col;

	// configuration registers, write always accepted
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FW_RESET;
			frame_height_q <= FH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[FW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[FH_W-1:0];
				default: ;
			endcase
		end
	end

	// effective dimensions, clamped to the supported range
	always_comb begin
		if (frame_width_q < FW_W'(MIN_DIM)) begin
			frame_w = FW_W'(MIN_DIM);
		end else if (frame_width_q > FW_W'(MAX_WIDTH)) begin
			frame_w = FW_W'(MAX_WIDTH);
		end else begin
			frame_w = frame_width_q;
		end
		if (frame_height_q < FH_W'(MIN_DIM)) begin
			frame_h = FH_W'(MIN_DIM);
		end else if (frame_height_q > FH_W'(MAX_HEIGHT)) begin
			frame_h = FH_W'(MAX_HEIGHT);
		end else begin
			frame_h = frame_height_q;
		end
	end

	// front: raster tracking, line ram, window, classification
	dmf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.pixel_depth (s_tdata[DEPTH_BITS-1:0]),
		.flush       (s_tuser),
		.frame_w     (frame_w),
		.frame_h     (frame_h),
		.q_full      (q_full),
		.push        (push)
	);

	// decoupling queue, only emitting pixels enter it
	dmf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.pop    (pop),
		.head   (head)
	);

	// back: median network and output register
	dmf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_depth (out_depth),
		.out_row   (out_row),
		.out_col   (out_col),
		.out_last  (m_tlast)
	);

	// pack result fields, lowest field first
	always_comb begin
		m_tdata = '0;
		m_tdata[OUT_ROW_LSB-1:OUT_DEPTH_LSB] = out_depth;
		m_tdata[OUT_COL_LSB-1:OUT_ROW_LSB]   = out_row;
		m_tdata[OUT_USED_W-1:OUT_COL_LSB]    = out_col;
	end

endmodule

>>> hdl/dmf_checker.sv
// ----------------------------------------------------------------------------
// dmf_checker
// Port-level checks of the median filter output stream, bound to the core.
// ----------------------------------------------------------------------------
module dmf_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [dmf_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic                            m_tlast
);
	import dmf_pkg::*;

	// a stalled result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// the last pixel of a frame is never on row or column 0 or 1
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |->
			(m_tdata[OUT_COL_LSB-1:OUT_ROW_LSB] >= OROW_W'(2))
			&& (m_tdata[OUT_USED_W-1:OUT_COL_LSB] >= OCOL_W'(2)))
		else $error("end of frame on an impossible position");

	// zero fill above the packed fields
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[OUT_TDATA_W-1:OUT_USED_W] == '0))
		else $error("tdata fill bits not zero");

endmodule

bind depth_median_filter_3x3_core dmf_checker u_dmf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 3x3 depth median filter core: drives whole
// frames of raster pixels with their flush tails, predicts every filtered
// pixel with its own line stores and window, and compares each output
// transaction field by field under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb;
	import dmf_pkg::*;

	localparam int          HALF_PERIOD      = 4;
	localparam int unsigned LIMIT_CYCLES     = 400000;
	localparam int unsigned SETTLE_CYCLES    = 16;
	localparam int unsigned HOLD_CYCLES      = 200;
	localparam int unsigned ITEMS_PER_PHASE  = 150;
	localparam int unsigned MAX_PRINTED      = 50;

	typedef enum int unsigned {
		FILL_UNIFORM,
		FILL_CLUSTERED,
		FILL_EXTREME
	} fill_style_t;

	typedef struct {
		pix_t              depth;
		logic [OROW_W-1:0] row;
		logic [OCOL_W-1:0] col;
		logic              eof;
	} filtered_pixel_t;

	// predicts the filtered stream and checks the output against it
	class median_scoreboard;
		logic [FW_W-1:0]   width_reg;
		logic [FH_W-1:0]   height_reg;
		pix_t              upper_line[MAX_WIDTH];
		pix_t              middle_line[MAX_WIDTH];
		pix_t              window[WIN_N];
		int unsigned       col_pos;
		int unsigned       row_pos;
		filtered_pixel_t   pending_pixels[$];
		int unsigned       error_count;

		function new();
			int i;
			for (i = 0; i < MAX_WIDTH; i++) begin
				upper_line[i]  = '0;
				middle_line[i] = '0;
			end
			for (i = 0; i < WIN_N; i++)
				window[i] = '0;
			width_reg   = FW_RESET;
			height_reg  = FH_RESET;
			col_pos     = 0;
			row_pos     = 0;
			error_count = 0;
		endfunction

		function void set_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
			if (idx == REG_FRAME_WIDTH)
				width_reg = value[FW_W-1:0];
			else
				height_reg = value[FH_W-1:0];
		endfunction

		function int unsigned frame_cols();
			if (width_reg < MIN_DIM)
				return MIN_DIM;
			if (width_reg > MAX_WIDTH)
				return MAX_WIDTH;
			return width_reg;
		endfunction

		function int unsigned frame_rows();
			if (height_reg < MIN_DIM)
				return MIN_DIM;
			if (height_reg > MAX_HEIGHT)
				return MAX_HEIGHT;
			return height_reg;
		endfunction

		function int unsigned pending();
			return pending_pixels.size();
		endfunction

		// the value with at most four smaller and at least five not larger
		function pix_t window_median();
			int i;
			int j;
			int unsigned below;
			int unsigned equal;
			for (i = 0; i < WIN_N; i++) begin
				below = 0;
				equal = 0;
				for (j = 0; j < WIN_N; j++) begin
					if (window[j] < window[i])
						below++;
					else if (window[j] == window[i])
						equal++;
				end
				if (below <= WIN_MID && below + equal > WIN_MID)
					return window[i];
			end
			return window[WIN_MID];
		endfunction

		function void accept_pixel(pix_t depth, logic flush);
			int unsigned     cols;
			int unsigned     rows;
			int unsigned     c;
			int unsigned     r;
			int unsigned     slot;
			int unsigned     orow;
			int unsigned     ocol;
			int              k;
			pix_t            d;
			pix_t            up;
			pix_t            mid;
			logic            emit;
			logic            eof;
			filtered_pixel_t px;
			cols = frame_cols();
			rows = frame_rows();
			c    = col_pos;
			r    = row_pos;
			d    = flush ? '0 : depth;
			slot = c % MAX_WIDTH;
			up   = upper_line[slot];
			mid  = middle_line[slot];
			upper_line[slot]  = mid;
			middle_line[slot] = d;
			for (k = 0; k < 3; k++) begin
				window[k * 3]     = window[k * 3 + 1];
				window[k * 3 + 1] = window[k * 3 + 2];
			end
			window[2] = up;
			window[5] = mid;
			window[8] = d;
			emit = (r >= 2) || (r == 1 && c >= 1);
			if (c >= 1) begin
				orow = r - 1;
				ocol = c - 1;
			end else begin
				orow = r - 2;
				ocol = cols - 1;
			end
			eof = (r >= rows + 1);
			// raster position advances; the second tail row closes the frame
			if (eof) begin
				row_pos = 0;
				col_pos = 0;
			end else if (c + 1 >= cols) begin
				col_pos = 0;
				row_pos = r + 1;
			end else begin
				col_pos = c + 1;
			end
			if (emit) begin
				if (orow == 0 || orow == rows - 1 || ocol == 0 || ocol == cols - 1)
					px.depth = window[WIN_MID];
				else
					px.depth = window_median();
				px.row = OROW_W'(orow);
				px.col = OCOL_W'(ocol);
				px.eof = eof;
				pending_pixels.push_back(px);
			end
		endfunction

		task report_mismatch(string what);
			if (error_count < MAX_PRINTED)
				$display("error: %s", what);
			error_count++;
		endtask

		task check_pixel(filtered_pixel_t got);
			filtered_pixel_t want;
			if (pending_pixels.size() == 0) begin
				report_mismatch($sformatf("unexpected pixel row %0d col %0d depth %h",
					got.row, got.col, got.depth));
				return;
			end
			want = pending_pixels.pop_front();
			if (got.depth !== want.depth)
				report_mismatch($sformatf("pixel (%0d,%0d) depth %h, predicted %h",
					want.row, want.col, got.depth, want.depth));
			if (got.row !== want.row)
				report_mismatch($sformatf("row %0d, predicted %0d", got.row, want.row));
			if (got.col !== want.col)
				report_mismatch($sformatf("col %0d, predicted %0d", got.col, want.col));
			if (got.eof !== want.eof)
				report_mismatch($sformatf("pixel (%0d,%0d) end of frame %b, predicted %b",
					want.row, want.col, got.eof, want.eof));
		endtask
	endclass

	// dut interface, every input known from time zero
	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;
	logic                   s_tuser   = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	median_scoreboard sb = new;
	filtered_pixel_t  seen_pixel;
	int unsigned      send_idle_pct = 0;
	int unsigned      recv_idle_pct = 0;
	int unsigned      sent_items    = 0;
	int unsigned      cycle_count   = 0;
	int unsigned      hold_requests = 0;

	depth_median_filter_3x3_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #HALF_PERIOD clk = ~clk;
	end

	// hang guard
	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("status: fail");
		$finish;
	end

	// every handshake is sampled at the edge that completes it
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.set_register(cfg_reg_t'(cfg_index), cfg_data);
			// inputs first, so a prediction always precedes its result
			if (s_tvalid && s_tready)
				sb.accept_pixel(s_tdata[DEPTH_BITS-1:0], s_tuser);
			if (m_tvalid && m_tready) begin
				seen_pixel.depth = m_tdata[OUT_DEPTH_LSB +: DEPTH_BITS];
				seen_pixel.row   = m_tdata[OUT_ROW_LSB +: OROW_W];
				seen_pixel.col   = m_tdata[OUT_COL_LSB +: OCOL_W];
				seen_pixel.eof   = m_tlast;
				sb.check_pixel(seen_pixel);
			end
		end
	end

	// sink: random stalls, plus one long hold-off on request so the
	// median pipeline and job queue fill and the source gets stalled
	initial begin : sink_ready
		int unsigned hold_left;
		int unsigned holds_served;
		hold_left    = 0;
		holds_served = 0;
		forever begin
			@(posedge clk);
			if (hold_requests != holds_served) begin
				holds_served = hold_requests;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// one pixel transaction, preceded by random idle cycles
	task automatic push_pixel(input pix_t depth, input logic flush);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= depth;
		s_tuser  <= flush;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent_items++;
	endtask

	// waits until every predicted pixel is out and the core has gone quiet
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// both registers back to back, valid held across the pair
	task automatic set_frame_size(input logic [CFG_DATA_W-1:0] cols_value,
			input logic [CFG_DATA_W-1:0] rows_value);
		cfg_valid <= 1'b1;
		cfg_index <= REG_FRAME_WIDTH;
		cfg_data  <= cols_value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_index <= REG_FRAME_HEIGHT;
		cfg_data  <= rows_value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// a full frame at the current size followed by its width + 1 tail items;
	// a few flushes land inside the frame, a few real pixels in the tail
	task automatic run_frame(input fill_style_t style);
		int unsigned cols;
		int unsigned rows;
		int unsigned n;
		pix_t        base;
		pix_t        depth;
		cols = sb.frame_cols();
		rows = sb.frame_rows();
		base = pix_t'($urandom);
		for (n = 0; n < cols * rows; n++) begin
			case (style)
				FILL_CLUSTERED: depth = base + pix_t'($urandom_range(3));
				FILL_EXTREME:   depth = $urandom_range(1) ? '1 : '0;
				default:        depth = pix_t'($urandom);
			endcase
			push_pixel(depth, $urandom_range(99) < 5);
		end
		for (n = 0; n <= cols; n++)
			push_pixel(pix_t'($urandom), $urandom_range(99) >= 15);
	endtask

	// size registers mostly small, now and then below the legal minimum
	task automatic random_frame();
		logic [CFG_DATA_W-1:0] cols_value;
		logic [CFG_DATA_W-1:0] rows_value;
		cols_value = ($urandom_range(9) == 0) ? CFG_DATA_W'($urandom_range(2))
			: CFG_DATA_W'($urandom_range(3, 10));
		rows_value = ($urandom_range(9) == 0) ? CFG_DATA_W'($urandom_range(2))
			: CFG_DATA_W'($urandom_range(3, 6));
		wait_drained();
		set_frame_size(cols_value, rows_value);
		run_frame(fill_style_t'($urandom_range(2)));
	endtask

	initial begin : stimulus
		int unsigned           phase;
		int unsigned           phase_start;
		logic [CFG_DATA_W-1:0] lead_cols[3];
		logic [CFG_DATA_W-1:0] lead_rows[3];
		// leading frame of each phase: height register at zero, width
		// register below minimum, and a wide frame for the long hold-off
		lead_cols = '{CFG_DATA_W'(8), CFG_DATA_W'(2), CFG_DATA_W'(10)};
		lead_rows = '{CFG_DATA_W'(0), CFG_DATA_W'(5), CFG_DATA_W'(6)};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed 3x3 frame (width register below minimum): extremes,
		// a flush in the bottom row, a median that differs from the center,
		// a real pixel in the tail
		set_frame_size(CFG_DATA_W'(2), CFG_DATA_W'(3));
		push_pixel(16'hFFFF, 1'b0);
		push_pixel(16'h0000, 1'b0);
		push_pixel(16'h8000, 1'b0);
		push_pixel(16'h0001, 1'b0);
		push_pixel(16'h1234, 1'b0);
		push_pixel(16'hFFFE, 1'b0);
		push_pixel(16'h5555, 1'b0);
		push_pixel(16'hFFFF, 1'b1);
		push_pixel(16'hAAAA, 1'b0);
		push_pixel(16'h0000, 1'b1);
		push_pixel(16'hFFFF, 1'b0);
		push_pixel(16'h0000, 1'b1);
		push_pixel(16'h0000, 1'b1);

		for (phase = 0; phase < 3; phase++) begin
			wait_drained();
			case (phase)
				0: begin
					send_idle_pct = 14;
					recv_idle_pct = 47;
				end
				1: begin
					send_idle_pct = 47;
					recv_idle_pct = 14;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			set_frame_size(lead_cols[phase], lead_rows[phase]);
			phase_start = sent_items;
			// long sink hold-off while the source keeps pushing the frame
			if (phase == 2)
				hold_requests++;
			run_frame(FILL_UNIFORM);
			while (sent_items - phase_start < ITEMS_PER_PHASE)
				random_frame();
		end

		wait_drained();
		if (sb.error_count == 0 && sb.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
